>>> rtl/core/sfd_pkg.sv
package sfd_pkg;

	// Frame layout
	localparam int FRAME_LEN  = 25;
	localparam int WIN_LEN    = FRAME_LEN - 1;
	localparam int DATA_BYTES = 22;
	localparam int FRAME_W    = DATA_BYTES * 8;
	localparam int NUM_CH     = 16;
	localparam int CH_BITS    = 11;
	localparam int CH_W       = 4;
	localparam int CNT_W      = 5;

	localparam logic [7:0]      FRAME_HEAD = 8'h0F;
	localparam logic [7:0]      FRAME_TAIL = 8'h00;
	localparam logic [CH_W-1:0] CH_LAST    = CH_W'(NUM_CH - 1);

	// Frame queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [7:0]         byte_t;
	typedef logic [FRAME_W-1:0] frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/core/sfd_front.sv
module sfd_front import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  byte_t     rx_byte,
	input  logic      in_valid,
	output logic      in_stall,
	input  q_status_t q_status,
	output logic      push,
	output frame_t    push_frame
);

	byte_t            win_q [WIN_LEN];
	logic [CNT_W-1:0] fill_q;
	logic             accept;
	logic             win_full;
	logic             match;

	// Hold off the byte stream while the frame queue has no room
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	// Frame check: 24 held bytes plus the incoming tail byte
	assign win_full = (fill_q == CNT_W'(WIN_LEN));
	assign match    = win_full && (win_q[0] == FRAME_HEAD) && (rx_byte == FRAME_TAIL);
	assign push     = accept && match;

	// Data bytes 1 to 22, byte 1 in the low bits
	always_comb begin
		for (int i = 0; i < DATA_BYTES; i++) begin
			push_frame[8*i +: 8] = win_q[i+1];
		end
	end

	// Window shift line, oldest byte at index 0
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_LEN-1] <= rx_byte;
		end
	end

	// Fill count saturates at 24; a good frame empties the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (match) begin
				fill_q <= '0;
			end else if (!win_full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/sfd_queue.sv
module sfd_queue import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  frame_t    push_frame,
	input  logic      pop,
	output frame_t    pop_frame,
	output q_status_t q_status
);

	frame_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_frame      = mem_q[rd_ptr_q];

	// Frame storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("frame queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("frame queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("frame queue count out of range");
`endif

endmodule

>>> rtl/core/sfd_back.sv
module sfd_back import sfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  q_status_t         q_status,
	input  frame_t            pop_frame,
	output logic              pop,
	output logic [CH_W-1:0]   channel_index,
	output logic [CH_BITS-1:0] channel_value,
	output logic              last_channel,
	output logic              out_valid,
	input  logic              out_stall
);

	frame_t            bits_q;
	logic [CH_W-1:0]   idx_q;
	logic              busy_q;
	logic              advance;
	logic              last_ch;

	// Take the next frame once the current one is fully unpacked
	assign pop     = !busy_q && !q_status.empty;
	assign advance = !out_valid || !out_stall;
	assign last_ch = (idx_q == CH_LAST);

	// Control: frame busy flag, channel counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				// previous frame's last channel may leave on this edge
				if (advance) begin
					out_valid <= 1'b0;
				end
			end else if (advance) begin
				out_valid <= busy_q;
				if (busy_q) begin
					idx_q <= idx_q + 1'b1;
					if (last_ch) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// Unpack: low 11 bits go out, frame shifts down one channel
	always_ff @(posedge clk) begin
		if (pop) begin
			bits_q <= pop_frame;
		end else if (advance && busy_q) begin
			bits_q        <= bits_q >> CH_BITS;
			channel_value <= bits_q[CH_BITS-1:0];
			channel_index <= idx_q;
			last_channel  <= last_ch;
		end
	end

`ifndef SYNTHESIS
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_channel |-> channel_index == CH_LAST)
		else $error("last flag on wrong channel");
	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_channel |=> out_valid)
		else $error("gap inside a frame's channel burst");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !busy_q && !out_valid || !busy_q)
		else $error("frame popped while unpacking");
`endif

endmodule

>>> rtl/core/sbus_frame_decoder.sv
// SBUS frame decoder, 16 channels. Accepts one received byte per cycle
// while in_stall is low and looks for a 25-byte frame that starts with 0x0F
// and ends with 0x00; while the stream is out of step it slides one byte at
// a time until it locks. Every good frame yields 16 transfers, channels 0
// to 15 in order, each an 11-bit value unpacked LSB-first from bytes 1 to
// 22, with last_channel set on channel 15. The flags byte is ignored.
// Output transfers leave one per cycle while out_stall is low, counted out
// by the unpacking counter after each frame is loaded from the queue. A
// two-frame queue separates byte intake from channel output: in_stall
// rises only when both queued frames are still waiting behind a stalled
// output.
module sbus_frame_decoder import sfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  byte_t              rx_byte,
	input  logic               in_valid,
	output logic               in_stall,
	output logic [CH_W-1:0]    channel_index,
	output logic [CH_BITS-1:0] channel_value,
	output logic               last_channel,
	output logic               out_valid,
	input  logic               out_stall
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	frame_t    push_frame;
	frame_t    pop_frame;

	// Byte intake and frame check
	sfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_status   (q_status),
		.push       (push),
		.push_frame (push_frame)
	);

	// Frame queue
	sfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.q_status   (q_status)
	);

	// Channel unpacking and output register
	sfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.pop_frame     (pop_frame),
		.pop           (pop),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last_channel  (last_channel),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

endmodule
